// ----- src/bcc_pkg.sv -----
// bcc_pkg: shared types and constants for the balance cascade controller
// no dependencies

package bcc_pkg;

  localparam int unsigned AccW = 48;

  localparam logic [2:0] CFG_ANGLE_KP = 3'd0;
  localparam logic [2:0] CFG_ANGLE_KD = 3'd1;
  localparam logic [2:0] CFG_SPEED_KP = 3'd2;
  localparam logic [2:0] CFG_SPEED_KI = 3'd3;
  localparam logic [2:0] CFG_POS_LIM  = 3'd4;
  localparam logic [2:0] CFG_DRV_LIM  = 3'd5;
  localparam logic [2:0] CFG_DEAD     = 3'd6;

  // serial multiply request/response
  typedef struct packed {
    logic             start;
    logic signed [AccW-1:0] mcand;
    logic [15:0]      mplier;
  } smul_req_t;

  typedef struct packed {
    logic             done;
    logic signed [AccW-1:0] prod;
  } smul_rsp_t;

endpackage

// ----- src/bcc_smul.sv -----
// bcc_smul: shift-add multiplier, one multiplier bit per cycle
// depends on bcc_pkg

module bcc_smul (
  input  logic                clk,
  input  logic                rst_n,
  input  bcc_pkg::smul_req_t  req,
  output bcc_pkg::smul_rsp_t  rsp
);

  logic signed [bcc_pkg::AccW-1:0] acc_r, mc_r;
  logic [15:0] mp_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        mc_r   <= req.mcand;
        mp_r   <= req.mplier;
      end else if (busy_r) begin
        if (mp_r[0]) acc_r <= acc_r + mc_r;
        mc_r  <= mc_r <<< 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- src/bcc_sdiv.sv -----
// bcc_sdiv: restoring unsigned divider, one quotient bit per cycle
// no package dependencies

module bcc_sdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [5:0]  divisor,
  output logic        done,
  output logic [47:0] quot
);

  logic [47:0] q_r;
  logic [6:0]  rem_r;
  logic [5:0]  dsor_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [6:0]  trial;

  assign trial = {rem_r[5:0], q_r[47]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        dsor_r <= divisor;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, dsor_r}) begin
          rem_r <= trial - {1'b0, dsor_r};
          q_r   <= {q_r[46:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- src/balance_cascade_controller.sv -----
// balance_cascade_controller: top level, sequencer and state
// depends on bcc_pkg, bcc_smul, bcc_sdiv

// A tick is taken on an in_valid/in_ready transfer and its result appears on out_valid,
// later on a tick that runs the speed loop. The arithmetic runs on a shared shift-add
// multiplier and a bit-serial divider, driven by a sequencer: a plain tick runs one ramp
// product, one ramp division and the two angle products and then forms the drives; the
// speed loop first adds the filter step, one filter division, the integral clamp, two PI
// products and the speed output saturation step. A new tick is taken in the idle cycle
// after the previous one finishes; the output register lets the next tick be computed
// while a result waits, and the sequencer holds at the drive step until that result has
// been taken. Configuration writes are taken only while the sequencer is idle.
module balance_cascade_controller #(
  parameter int unsigned SPEED_PERIOD = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [16:0] in_tilt_angle,
  input  logic signed [15:0] in_gyro_rate,
  input  logic signed [15:0] in_left_pulses,
  input  logic signed [15:0] in_right_pulses,
  input  logic signed [11:0] in_speed_target,
  input  logic signed [9:0]  in_steer_offset,
  input  logic               in_halt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] out_left_drive,
  output logic signed [12:0] out_right_drive,
  output logic               out_speed_updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int unsigned W = bcc_pkg::AccW;
  localparam logic [4:0] PerLast = 5'(SPEED_PERIOD - 1);
  localparam logic [5:0] PerDiv  = 6'(SPEED_PERIOD);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FILT  = 12'b000000000010,
    S_FDIV  = 12'b000000000100,
    S_CLAMP = 12'b000000001000,
    S_PI1   = 12'b000000010000,
    S_PI2   = 12'b000000100000,
    S_PI3   = 12'b000001000000,
    S_RAMP  = 12'b000010000000,
    S_RDIV  = 12'b000100000000,
    S_TILT  = 12'b001000000000,
    S_GYRO  = 12'b010000000000,
    S_WHEEL = 12'b100000000000
  } state_t;

  state_t state_r;

  logic [15:0] kp_a_r, kd_a_r, kp_s_r, ki_s_r;
  logic [14:0] pos_lim_r;
  logic [11:0] drv_lim_r;
  logic [9:0]  dead_r;

  logic [4:0]  per_r;
  logic signed [23:0] lsum_r, rsum_r, filt_r;
  logic signed [19:0] pint_r;
  logic signed [31:0] old_r, new_r;

  logic signed [16:0] tilt_r;
  logic signed [15:0] gyro_r;
  logic signed [11:0] tgt_r;
  logic signed [9:0]  steer_r;
  logic               halt_r, upd_r;
  logic signed [W-1:0] acc_r, tmp_r;
  logic               neg_r, go_r;

  logic signed [12:0] ld_r, rd_r;
  logic               ov_r, oupd_r;
  logic               drv_load;

  bcc_pkg::smul_req_t mreq;
  bcc_pkg::smul_rsp_t mrsp;
  logic        dstart, ddone;
  logic [W-1:0] ddiv, dq;
  logic [5:0]  dsor;

  bcc_smul u_mul (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  bcc_sdiv u_div (.clk, .rst_n, .start(dstart), .dividend(ddiv), .divisor(dsor),
                  .done(ddone), .quot(dq));

  assign cfg_ready = (state_r == S_IDLE);
  // a tick and a register write never share an edge
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  // the drives go to the output register once the previous result has left
  assign drv_load = (state_r == S_WHEEL) && (!ov_r || out_ready);

  // sign-magnitude helpers
  logic [W-1:0] absacc;
  assign absacc = acc_r[W-1] ? W'(-acc_r) : W'(acc_r);

  function automatic logic signed [12:0] wheel_f(input logic signed [W-1:0] q16,
      input logic [9:0] dz, input logic [11:0] lim);
    logic [W-1:0] mag;
    logic [W-17:0] t;
    logic [W-16:0] td;
    logic [12:0] r;
    mag = q16[W-1] ? W'(-q16) : W'(q16);
    t   = mag[W-1:16];
    td  = (t == '0) ? '0 : ({1'b0, t} + (W-15)'(dz));
    r   = (td > (W-15)'(lim)) ? {1'b0, lim} : 13'(td);
    return q16[W-1] ? 13'(-r) : 13'(r);
  endfunction

  function automatic logic signed [23:0] fsat_of(input logic signed [W-1:0] v);
    return (v > W'(24'sh7fffff)) ? 24'sh7fffff :
           (v < -W'(25'sh0800000)) ? 24'sh800000 : 24'(v);
  endfunction

  logic signed [W-1:0] base_l, base_r;
  assign base_l = acc_r - (W'(steer_r) <<< 16);
  assign base_r = acc_r + (W'(steer_r) <<< 16);

  logic signed [W-1:0] sum2, half, lim16, pint_sum;
  logic signed [24:0] err;
  assign sum2 = W'(lsum_r) + W'(rsum_r);
  assign half = (sum2 + W'(sum2[W-1])) >>> 1;
  assign lim16 = W'({pos_lim_r, 4'b0});
  assign err = 25'(tgt_r) - 25'(filt_r);
  assign pint_sum = W'(pint_r) + W'(err);

  always_comb begin
    mreq = '0;
    dstart = 1'b0;
    ddiv = '0;
    dsor = PerDiv;
    unique case (state_r)
      S_TILT: if (go_r) begin
        mreq.start = 1'b1; mreq.mcand = W'(tilt_r); mreq.mplier = kp_a_r;
      end
      S_GYRO: if (go_r) begin
        mreq.start = 1'b1; mreq.mcand = W'(gyro_r) <<< 4; mreq.mplier = kd_a_r;
      end
      S_PI1: if (go_r) begin
        mreq.start = 1'b1; mreq.mcand = W'(err) <<< 4; mreq.mplier = kp_s_r;
      end
      S_PI2: if (go_r) begin
        mreq.start = 1'b1; mreq.mcand = W'(pint_r) <<< 4; mreq.mplier = ki_s_r;
      end
      S_FDIV: if (go_r) begin
        dstart = 1'b1; ddiv = absacc + W'(5); dsor = 6'd10;
      end
      S_RDIV: if (go_r) begin
        dstart = 1'b1; ddiv = absacc; dsor = PerDiv;
      end
      S_RAMP: if (go_r) begin
        mreq.start = 1'b1; mreq.mcand = W'(new_r) - W'(old_r);
        mreq.mplier = 16'(per_r) + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (drv_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kp_a_r <= 16'd16640; kd_a_r <= 16'd589; kp_s_r <= 16'd2624; ki_s_r <= 16'd28;
      pos_lim_r <= 15'd900; drv_lim_r <= 12'd1000; dead_r <= 10'd0;
      per_r <= '0; lsum_r <= '0; rsum_r <= '0; filt_r <= '0; pint_r <= '0;
      old_r <= '0; new_r <= '0; go_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              bcc_pkg::CFG_ANGLE_KP: kp_a_r <= cfg_data;
              bcc_pkg::CFG_ANGLE_KD: kd_a_r <= cfg_data;
              bcc_pkg::CFG_SPEED_KP: kp_s_r <= cfg_data;
              bcc_pkg::CFG_SPEED_KI: ki_s_r <= cfg_data;
              bcc_pkg::CFG_POS_LIM:  pos_lim_r <= cfg_data[14:0];
              bcc_pkg::CFG_DRV_LIM:  drv_lim_r <= cfg_data[11:0];
              bcc_pkg::CFG_DEAD:     dead_r <= cfg_data[9:0];
              default: ;
            endcase
          end else if (in_valid) begin
            tilt_r <= in_tilt_angle; gyro_r <= in_gyro_rate;
            tgt_r <= in_speed_target; steer_r <= in_steer_offset; halt_r <= in_halt;
            lsum_r <= lsum_r + 24'(in_left_pulses);
            rsum_r <= rsum_r + 24'(in_right_pulses);
            upd_r  <= (per_r >= PerLast);
            state_r <= (per_r >= PerLast) ? S_FILT : S_RAMP;
            per_r <= (per_r >= PerLast) ? 5'd0 : per_r + 5'd1;
            go_r <= 1'b1;
          end
        end
        S_FILT: begin
          // 7*filt + 48*half by shifts
          acc_r <= (W'(filt_r) <<< 3) - W'(filt_r) + (half <<< 5) + (half <<< 4);
          state_r <= S_FDIV; go_r <= 1'b1;
        end
        S_FDIV: begin
          if (go_r) neg_r <= acc_r[W-1];
          if (ddone) begin
            filt_r <= fsat_of(neg_r ? -$signed(dq) : $signed(dq));
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // integral takes the new error before the PI products start
          pint_r <= (pint_sum > lim16) ? 20'(lim16) :
                    (pint_sum < -lim16) ? 20'(-lim16) : 20'(pint_sum);
          state_r <= S_PI1; go_r <= 1'b1;
        end
        S_PI1: begin
          if (mrsp.done) begin
            tmp_r <= mrsp.prod;
            state_r <= S_PI2; go_r <= 1'b1;
          end
        end
        S_PI2: begin
          if (mrsp.done) begin
            acc_r <= tmp_r + mrsp.prod;
            state_r <= S_PI3;
          end
        end
        S_PI3: begin
          old_r <= new_r;
          new_r <= (acc_r > W'(32'sh7fffffff)) ? 32'sh7fffffff :
                   (acc_r < -W'(33'sh080000000)) ? 32'sh80000000 : 32'(acc_r);
          lsum_r <= '0; rsum_r <= '0;
          state_r <= S_RAMP; go_r <= 1'b1;
        end
        S_RAMP: begin
          if (mrsp.done) begin
            acc_r <= mrsp.prod;
            state_r <= S_RDIV; go_r <= 1'b1;
          end
        end
        S_RDIV: begin
          if (go_r) neg_r <= acc_r[W-1];
          if (ddone) begin
            tmp_r <= (neg_r ? -$signed(dq) : $signed(dq)) + W'(old_r);
            state_r <= S_TILT; go_r <= 1'b1;
          end
        end
        S_TILT: begin
          if (mrsp.done) begin
            acc_r <= -mrsp.prod - tmp_r;
            state_r <= S_GYRO; go_r <= 1'b1;
          end
        end
        S_GYRO: begin
          if (mrsp.done) begin
            acc_r <= acc_r - mrsp.prod;
            state_r <= S_WHEEL;
          end
        end
        S_WHEEL: begin
          if (drv_load) begin
            ld_r <= halt_r ? 13'sd0 : wheel_f(base_l, dead_r, drv_lim_r);
            rd_r <= halt_r ? 13'sd0 : wheel_f(base_r, dead_r, drv_lim_r);
            oupd_r <= upd_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_left_drive = ld_r;
  assign out_right_drive = rd_r;
  assign out_speed_updated = oupd_r;

endmodule

// ----- dv/balance_cascade_controller_tb.sv -----
// balance_cascade_controller_tb: self-checking bench for the balance cascade controller
// predicts every tick's wheel drives and speed-update flag and checks them per transfer
// depends on bcc_pkg and balance_cascade_controller
`timescale 1ns / 100ps

module balance_cascade_controller_tb;

  localparam int Period = 25;

  typedef struct packed {
    logic signed [12:0] left_drive;
    logic signed [12:0] right_drive;
    logic               speed_updated;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [16:0] in_tilt_angle = '0;
  logic signed [15:0] in_gyro_rate = '0;
  logic signed [15:0] in_left_pulses = '0;
  logic signed [15:0] in_right_pulses = '0;
  logic signed [11:0] in_speed_target = '0;
  logic signed [9:0]  in_steer_offset = '0;
  logic in_halt = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [12:0] out_left_drive;
  logic signed [12:0] out_right_drive;
  logic out_speed_updated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  balance_cascade_controller #(.SPEED_PERIOD(Period)) i_dut (.*);

  initial forever #6 clk = ~clk;

  // predictor state and register copy
  longint kp_angle, kd_angle, kp_speed, ki_speed, pos_lim, drv_lim, dead;
  int unsigned tick_count;
  longint sum_l, sum_r, filt, integ, spd_old, spd_new;

  drive_t expected_drives[$];
  int errors = 0;
  bit hold_off = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap24(longint v);
    logic signed [23:0] w;
    w = v[23:0];
    return longint'(w);
  endfunction

  function automatic longint to_wheel(longint q16);
    longint t;
    t = q16 / 65536;
    if (t > 0) t += dead;
    else if (t < 0) t -= dead;
    return clip(t, -drv_lim, drv_lim);
  endfunction

  task automatic predict_tick(longint tilt, longint gyro, longint lp, longint rp,
                              longint target, longint steer, bit halt);
    longint half, v, f, err, lim, nv, ramp, base, ld, rd;
    bit upd;
    drive_t d;
    upd = 1'b0;
    sum_l = wrap24(sum_l + lp);
    sum_r = wrap24(sum_r + rp);
    if (tick_count + 1 >= Period) begin
      half = (sum_l + sum_r) / 2;
      v = 7 * filt + 48 * half;
      f = v >= 0 ? (v + 5) / 10 : -((-v + 5) / 10);
      filt = clip(f, -8388608, 8388607);
      err = target - filt;
      lim = pos_lim * 16;
      integ = clip(integ + err, -lim, lim);
      nv = err * kp_speed * 16 + integ * ki_speed * 16;
      spd_old = spd_new;
      spd_new = clip(nv, -64'sd2147483648, 64'sd2147483647);
      sum_l = 0;
      sum_r = 0;
      tick_count = 0;
      upd = 1'b1;
    end else begin
      tick_count++;
    end
    ramp = (spd_new - spd_old) * longint'(tick_count + 1) / longint'(Period) + spd_old;
    base = -(tilt * kp_angle) - gyro * kd_angle * 16 - ramp;
    ld = to_wheel(base - steer * 65536);
    rd = to_wheel(base + steer * 65536);
    if (halt) begin
      ld = 0;
      rd = 0;
    end
    d.left_drive = ld[12:0];
    d.right_drive = rd[12:0];
    d.speed_updated = upd;
    expected_drives.push_back(d);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bcc_pkg::CFG_ANGLE_KP: kp_angle = val;
      bcc_pkg::CFG_ANGLE_KD: kd_angle = val;
      bcc_pkg::CFG_SPEED_KP: kp_speed = val;
      bcc_pkg::CFG_SPEED_KI: ki_speed = val;
      bcc_pkg::CFG_POS_LIM:  pos_lim = val[14:0];
      bcc_pkg::CFG_DRV_LIM:  drv_lim = val[11:0];
      bcc_pkg::CFG_DEAD:     dead = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one transfer on the tick channel; valid held across back-to-back ticks
  task automatic send_tick(logic signed [16:0] tilt, logic signed [15:0] gyro,
                           logic signed [15:0] lp, logic signed [15:0] rp,
                           logic signed [11:0] target, logic signed [9:0] steer,
                           logic halt, bit keep_valid);
    in_tilt_angle <= tilt;
    in_gyro_rate <= gyro;
    in_left_pulses <= lp;
    in_right_pulses <= rp;
    in_speed_target <= target;
    in_steer_offset <= steer;
    in_halt <= halt;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_tick(tilt, gyro, lp, rp, target, steer, halt);
    if (!keep_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random(int n, bit wide);
    int burst;
    logic signed [16:0] tilt;
    logic signed [15:0] gyro, lp, rp;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
      burst--;
      tilt = wide ? 17'($urandom_range(0, 92160) - 46080) :
                    17'($urandom_range(0, 4000) - 2000);
      gyro = wide ? 16'($urandom_range(0, 64000) - 32000) :
                    16'($urandom_range(0, 2000) - 1000);
      lp = wide ? 16'($urandom) : 16'($urandom_range(0, 80) - 40);
      rp = wide ? 16'($urandom) : 16'($urandom_range(0, 80) - 40);
      send_tick(tilt, gyro, lp, rp, 12'($urandom_range(0, 2240) - 1120),
                10'($urandom_range(0, 800) - 400), $urandom_range(0, 15) == 0,
                burst != 0 && i != n - 1);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_drives.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic test_directed();
    send_tick(17'sd46080, 16'sd32000, 16'sd32767, 16'sd32767, 12'sd1120, 10'sd400,
              1'b0, 1'b0);
    send_tick(-17'sd46080, -16'sd32000, 16'sh8000, 16'sh8000, -12'sd1120, -10'sd400,
              1'b0, 1'b0);
    send_tick(17'sd0, 16'sd0, 16'sd0, 16'sd0, 12'sd0, 10'sd0, 1'b0, 1'b0);
    send_tick(17'sd300, -16'sd50, 16'sd5, -16'sd3, 12'sd100, 10'sd20, 1'b1, 1'b0);
    send_tick(-17'sd1, 16'sd1, 16'sd1, 16'sd1, -12'sd1, -10'sd1, 1'b0, 1'b0);
    // run through a full period so the speed loop fires, including at full pulse rates
    for (int i = 0; i < 20; i++)
      send_tick(i[0] ? 17'sd46080 : -17'sd46080, 16'sd0, 16'sd32767, 16'sd32767,
                12'sd1120, 10'sd0, i == 7, 1'b1);
    in_valid <= 1'b0;
    drain();
  endtask

  task automatic test_limits();
    // zero limits
    write_reg(bcc_pkg::CFG_POS_LIM, 16'd0);
    write_reg(bcc_pkg::CFG_DRV_LIM, 16'd0);
    write_reg(bcc_pkg::CFG_DEAD, 16'd0);
    send_random(30, 1'b0);
    drain();
    // largest gains and limits: saturation of filter and speed output
    write_reg(bcc_pkg::CFG_ANGLE_KP, 16'hFFFF);
    write_reg(bcc_pkg::CFG_ANGLE_KD, 16'hFFFF);
    write_reg(bcc_pkg::CFG_SPEED_KP, 16'hFFFF);
    write_reg(bcc_pkg::CFG_SPEED_KI, 16'hFFFF);
    write_reg(bcc_pkg::CFG_POS_LIM, 16'h7FFF);
    write_reg(bcc_pkg::CFG_DRV_LIM, 16'hFFF);
    write_reg(bcc_pkg::CFG_DEAD, 16'd1000);
    send_random(80, 1'b1);
    drain();
    // tiny limits, small gains
    write_reg(bcc_pkg::CFG_ANGLE_KP, 16'd1);
    write_reg(bcc_pkg::CFG_ANGLE_KD, 16'd0);
    write_reg(bcc_pkg::CFG_SPEED_KP, 16'd3);
    write_reg(bcc_pkg::CFG_SPEED_KI, 16'd0);
    write_reg(bcc_pkg::CFG_POS_LIM, 16'd1);
    write_reg(bcc_pkg::CFG_DRV_LIM, 16'd1);
    write_reg(bcc_pkg::CFG_DEAD, 16'd1);
    send_random(60, 1'b0);
    drain();
  endtask

  task automatic test_random();
    write_reg(bcc_pkg::CFG_ANGLE_KP, 16'd16640);
    write_reg(bcc_pkg::CFG_ANGLE_KD, 16'd589);
    write_reg(bcc_pkg::CFG_SPEED_KP, 16'd2624);
    write_reg(bcc_pkg::CFG_SPEED_KI, 16'd28);
    write_reg(bcc_pkg::CFG_POS_LIM, 16'd900);
    write_reg(bcc_pkg::CFG_DRV_LIM, 16'd1000);
    write_reg(bcc_pkg::CFG_DEAD, 16'd30);
    send_random(200, 1'b0);
    drain();
    for (int r = 0; r < 7; r++) write_reg(3'(r), 16'($urandom));
    send_random(100, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_random(40, 1'b0);
    drain();
  endtask

  // receiver stall pattern, with a long hold-off while the sender keeps offering
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      out_ready <= mode == 0 ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (mode == 0) repeat ($urandom_range(1, 300)) @(posedge clk);
    end
  end

  // result checker, sampled at the edge
  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected transfer L=%0d R=%0d U=%0d", $time,
                 out_left_drive, out_right_drive, out_speed_updated);
        errors++;
      end else begin
        want = expected_drives.pop_front();
        if (out_left_drive !== want.left_drive) begin
          $display("%0t: left_drive expected %0d actual %0d", $time,
                   want.left_drive, out_left_drive);
          errors++;
        end
        if (out_right_drive !== want.right_drive) begin
          $display("%0t: right_drive expected %0d actual %0d", $time,
                   want.right_drive, out_right_drive);
          errors++;
        end
        if (out_speed_updated !== want.speed_updated) begin
          $display("%0t: speed_updated expected %0d actual %0d", $time,
                   want.speed_updated, out_speed_updated);
          errors++;
        end
      end
    end
  end

  initial begin
    kp_angle = 16640; kd_angle = 589; kp_speed = 2624; ki_speed = 28;
    pos_lim = 900; drv_lim = 1000; dead = 0;
    tick_count = 0; sum_l = 0; sum_r = 0; filt = 0; integ = 0;
    spd_old = 0; spd_new = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    test_backpressure();
    if (errors == 0 && expected_drives.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // slowest run: ~540 ticks plus stalls, well under this
  initial begin
    #(12 * 3000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
